### sv/cbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_pkg: shared types and constants of the contention round block
// Field widths, outcome and command codes, register indexes, reset values and
// the per-round control word sent to every station slice.
// ----------------------------------------------------------------------------
package cbcs_pkg;

    // parameter defaults
    localparam int NUM_STATIONS_DEF = 4;
    localparam int RAND_BITS_DEF    = 16;

    // fixed field widths
    localparam int MAX_STATIONS = 4;
    localparam int LANE_W       = 16;
    localparam int RND_W        = MAX_STATIONS * LANE_W;
    localparam int BO_W         = 15;
    localparam int EXP_W        = 4;
    localparam int RMAX_W       = 8;
    localparam int THR_W        = 16;
    localparam int TX_W         = 8;
    localparam int CNT_W        = 32;
    localparam int TIME_W       = 48;
    localparam int OUTCOME_W    = 3;
    localparam int WIN_W        = 2;
    localparam int MASK_W       = MAX_STATIONS;

    // stream word widths
    localparam int IN_DATA_W   = 72;
    localparam int RES_W       = OUTCOME_W + WIN_W + MASK_W + TX_W + 2 * CNT_W + TIME_W;
    localparam int OUT_DATA_W  = ((RES_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EXP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EXP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAND_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

    // register reset values
    localparam logic             MODE_RST      = 1'b0;
    localparam logic [EXP_W-1:0] INIT_EXP_RST  = 4'd5;
    localparam logic [EXP_W-1:0] MAX_EXP_RST   = 4'd15;
    localparam logic [RMAX_W-1:0] RAND_MAX_RST = 8'd6;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd39322;

    // backoff modes
    localparam logic MODE_BEB     = 1'b0;
    localparam logic MODE_PERSIST = 1'b1;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ROUND = 1'b1;

    // round outcomes
    localparam logic [OUTCOME_W-1:0] OUT_IDLE      = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_COLLISION = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_SUCCESS   = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_DEFERRED  = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_INIT      = 3'd4;

    // per-round control word broadcast to the station slices
    typedef struct packed {
        logic              start;
        logic              idle;
        logic              collide;
        logic              success;
        logic              defer;
        logic              mode;
        logic [EXP_W-1:0]  init_exp;
        logic [EXP_W-1:0]  max_exp;
        logic [RMAX_W-1:0] rand_max;
        logic [THR_W-1:0]  persist_threshold;
        logic [TX_W-1:0]   tx_slots;
    } round_ctl_t;

endpackage

### sv/cbcs_station.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbcs_station: state and next-state logic of one station
// Holds backoff count, exponent, attempt and success counts and updates them
// once per round from the broadcast control word and the station's lane.
// ----------------------------------------------------------------------------
module cbcs_station #(
    parameter int RAND_BITS = cbcs_pkg::RAND_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  cbcs_pkg::round_ctl_t      ctl,
    input  logic [RAND_BITS-1:0]      lane,
    output logic                      ready,
    output logic                      defer_req,
    output logic [cbcs_pkg::CNT_W-1:0] attempts_next,
    output logic [cbcs_pkg::CNT_W-1:0] successes_next
);

    localparam int WIDE_W = RAND_BITS + cbcs_pkg::BO_W;
    localparam int PROD_W = RAND_BITS + cbcs_pkg::RMAX_W + 1;

    logic [cbcs_pkg::BO_W-1:0]  backoff_reg, backoff_next;
    logic [cbcs_pkg::EXP_W-1:0] exp_reg, exp_next;
    logic [cbcs_pkg::CNT_W-1:0] att_reg, suc_reg;

    logic [cbcs_pkg::EXP_W-1:0]  draw_exp;
    logic [WIDE_W-1:0]           wide;
    logic [cbcs_pkg::BO_W-1:0]   pow_draw;
    logic [cbcs_pkg::RMAX_W:0]   span;
    logic [PROD_W-1:0]           prod;
    logic [cbcs_pkg::BO_W-1:0]   uni_draw;
    logic [cbcs_pkg::LANE_W-1:0] scaled;
    logic [cbcs_pkg::BO_W-1:0]   tx_ext;
    logic [cbcs_pkg::CNT_W-1:0]  att_inc, suc_inc;

    // draw in 0..2^e-1: lane times a power of two, top bits kept
    assign draw_exp = (ctl.start || ctl.success) ? ctl.init_exp : exp_reg;
    assign wide     = WIDE_W'(lane) << draw_exp;
    assign pow_draw = wide[WIDE_W-1:RAND_BITS];

    // draw in 0..random_max
    assign span     = {1'b0, ctl.rand_max} + 9'd1;
    assign prod     = PROD_W'(lane) * PROD_W'(span);
    assign uni_draw = cbcs_pkg::BO_W'(prod[PROD_W-1:RAND_BITS]);

    // defer test on the lane scaled to 16 bits
    assign scaled    = cbcs_pkg::LANE_W'(lane) << (cbcs_pkg::LANE_W - RAND_BITS);
    assign defer_req = scaled > ctl.persist_threshold;

    assign ready   = (backoff_reg == '0);
    assign att_inc = (att_reg == '1) ? att_reg : att_reg + 1'b1;
    assign suc_inc = (suc_reg == '1) ? suc_reg : suc_reg + 1'b1;
    assign tx_ext  = cbcs_pkg::BO_W'(ctl.tx_slots);

    // next state for this round
    always_comb
    begin
        backoff_next   = backoff_reg;
        exp_next       = exp_reg;
        attempts_next  = att_reg;
        successes_next = suc_reg;
        if (ctl.start)
        begin
            attempts_next  = '0;
            successes_next = '0;
            exp_next       = ctl.init_exp;
            if (ctl.mode == cbcs_pkg::MODE_BEB)
                backoff_next = pow_draw;
            else
                backoff_next = cbcs_pkg::BO_W'(defer_req);
        end
        else if (ctl.idle)
        begin
            if (backoff_reg != '0)
                backoff_next = backoff_reg - 1'b1;
        end
        else if (ctl.collide)
        begin
            if (ready)
            begin
                attempts_next = att_inc;
                if (ctl.mode == cbcs_pkg::MODE_BEB)
                begin
                    backoff_next = pow_draw;
                    if (exp_reg < ctl.max_exp)
                        exp_next = exp_reg + 1'b1;
                end
                else
                begin
                    backoff_next = uni_draw;
                end
            end
        end
        else if (ctl.defer)
        begin
            if (ready)
                backoff_next = cbcs_pkg::BO_W'(1);
        end
        else if (ctl.success)
        begin
            if (ready)
            begin
                attempts_next  = att_inc;
                successes_next = suc_inc;
                if (ctl.mode == cbcs_pkg::MODE_BEB)
                begin
                    exp_next     = ctl.init_exp;
                    backoff_next = pow_draw;
                end
                else
                begin
                    backoff_next = '0;
                end
            end
            else if (ctl.mode == cbcs_pkg::MODE_PERSIST)
            begin
                backoff_next = (backoff_reg < tx_ext) ? '0 : backoff_reg - tx_ext;
            end
        end
    end

    // station state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_reg <= '0;
            exp_reg     <= '0;
            att_reg     <= '0;
            suc_reg     <= '0;
        end
        else if (en)
        begin
            backoff_reg <= backoff_next;
            exp_reg     <= exp_next;
            att_reg     <= attempts_next;
            suc_reg     <= successes_next;
        end
    end

endmodule

### sv/csma_backoff_contention_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_backoff_contention_step: one contention round of a slotted channel
// Handles a start command, or classifies a round as idle, collision, success or
// deferred from the station backoff counters, and updates all stations in parallel.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    s_tdata: station_random, tx_slots
//                                        s_tuser: cmd
//   m_*      out  m_tvalid / m_tready    m_tdata: round result
//   cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained unless m_tready holds the result register.
// A word sits in the input register, one pass of logic updates every station
// and the channel time and loads the result register in the same cycle.
// s_tready drops only while both the input and result registers are full and
// m_tready is low. Reset clears the valid flags, station state and channel time
// and loads register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module csma_backoff_contention_step #(
    parameter int NUM_STATIONS = cbcs_pkg::NUM_STATIONS_DEF,
    parameter int RAND_BITS    = cbcs_pkg::RAND_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [63:0] station_random, [71:64] tx_slots
    input  logic [cbcs_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] cmd
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] outcome, [4:3] winner, [8:5] collision_mask, [16:9] slots_advanced,
    // [48:17] winner_attempts, [80:49] winner_successes, [128:81] total_slots
    output logic [cbcs_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_ST_W = $clog2(NUM_STATIONS + 1);

    // configuration registers
    logic                          mode_reg;
    logic [cbcs_pkg::EXP_W-1:0]    init_exp_reg;
    logic [cbcs_pkg::EXP_W-1:0]    max_exp_reg;
    logic [cbcs_pkg::RMAX_W-1:0]   rand_max_reg;
    logic [cbcs_pkg::THR_W-1:0]    thr_reg;

    // input register
    logic                          in_valid_reg;
    logic                          cmd_reg;
    logic [cbcs_pkg::RND_W-1:0]    rnd_reg;
    logic [cbcs_pkg::TX_W-1:0]     tx_reg;

    // result register
    logic                          out_valid_reg;
    logic [cbcs_pkg::RES_W-1:0]    res_reg, res_next;

    logic [cbcs_pkg::TIME_W-1:0]   time_reg, time_next;

    logic                          advance;
    cbcs_pkg::round_ctl_t          ctl;
    logic [NUM_STATIONS-1:0]       ready, defer_req;
    logic [cbcs_pkg::CNT_W-1:0]    att_next [NUM_STATIONS];
    logic [cbcs_pkg::CNT_W-1:0]    suc_next [NUM_STATIONS];

    logic [CNT_ST_W-1:0]           num_ready;
    logic [cbcs_pkg::WIN_W-1:0]    win_idx;
    logic [cbcs_pkg::MASK_W-1:0]   mask;
    logic                          win_defer;
    logic [cbcs_pkg::CNT_W-1:0]    win_att, win_suc;
    logic                          is_start, is_idle, is_coll, is_single;
    logic [cbcs_pkg::TIME_W:0]     time_sum;
    logic [cbcs_pkg::TX_W-1:0]     add_slots;

    logic [cbcs_pkg::OUTCOME_W-1:0] r_outcome;
    logic [cbcs_pkg::WIN_W-1:0]     r_winner;
    logic [cbcs_pkg::MASK_W-1:0]    r_mask;
    logic [cbcs_pkg::TX_W-1:0]      r_slots;
    logic [cbcs_pkg::CNT_W-1:0]     r_att, r_suc;
    logic [cbcs_pkg::TIME_W-1:0]    r_time;

    // handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tdata   = cbcs_pkg::OUT_DATA_W'(res_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= cbcs_pkg::MODE_RST;
            init_exp_reg <= cbcs_pkg::INIT_EXP_RST;
            max_exp_reg  <= cbcs_pkg::MAX_EXP_RST;
            rand_max_reg <= cbcs_pkg::RAND_MAX_RST;
            thr_reg      <= cbcs_pkg::THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbcs_pkg::REG_MODE:      mode_reg     <= cfg_data[0];
                cbcs_pkg::REG_INIT_EXP:  init_exp_reg <= cfg_data[cbcs_pkg::EXP_W-1:0];
                cbcs_pkg::REG_MAX_EXP:   max_exp_reg  <= cfg_data[cbcs_pkg::EXP_W-1:0];
                cbcs_pkg::REG_RAND_MAX:  rand_max_reg <= cfg_data[cbcs_pkg::RMAX_W-1:0];
                cbcs_pkg::REG_THRESHOLD: thr_reg      <= cfg_data[cbcs_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            rnd_reg <= s_tdata[cbcs_pkg::RND_W-1:0];
            tx_reg  <= s_tdata[cbcs_pkg::RND_W +: cbcs_pkg::TX_W];
        end
    end

    // ready stations: mask, count and last ready index
    always_comb
    begin
        num_ready = '0;
        win_idx   = '0;
        mask      = '0;
        for (int i = 0; i < NUM_STATIONS; i++)
        begin
            if (ready[i])
            begin
                mask[i]   = 1'b1;
                num_ready = num_ready + 1'b1;
                win_idx   = cbcs_pkg::WIN_W'(i);
            end
        end
    end

    // winner's defer request and updated counts
    always_comb
    begin
        win_defer = 1'b0;
        win_att   = '0;
        win_suc   = '0;
        for (int i = 0; i < NUM_STATIONS; i++)
        begin
            if (win_idx == cbcs_pkg::WIN_W'(i))
            begin
                win_defer = defer_req[i];
                win_att   = att_next[i];
                win_suc   = suc_next[i];
            end
        end
    end

    // round classification
    assign is_start  = (cmd_reg == cbcs_pkg::CMD_START);
    assign is_idle   = !is_start && (num_ready == '0);
    assign is_coll   = !is_start && (num_ready > CNT_ST_W'(1));
    assign is_single = !is_start && (num_ready == CNT_ST_W'(1));

    always_comb
    begin
        ctl.start             = is_start;
        ctl.idle              = is_idle;
        ctl.collide           = is_coll;
        ctl.defer             = is_single && (mode_reg == cbcs_pkg::MODE_PERSIST) && win_defer;
        ctl.success           = is_single && !ctl.defer;
        ctl.mode              = mode_reg;
        ctl.init_exp          = init_exp_reg;
        ctl.max_exp           = max_exp_reg;
        ctl.rand_max          = rand_max_reg;
        ctl.persist_threshold = thr_reg;
        ctl.tx_slots          = tx_reg;
    end

    // station slices
    for (genvar g = 0; g < NUM_STATIONS; g++)
    begin : g_sta
        cbcs_station #(
            .RAND_BITS (RAND_BITS)
        ) u_sta (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (advance),
            .ctl            (ctl),
            .lane           (rnd_reg[g*cbcs_pkg::LANE_W +: RAND_BITS]),
            .ready          (ready[g]),
            .defer_req      (defer_req[g]),
            .attempts_next  (att_next[g]),
            .successes_next (suc_next[g])
        );
    end

    // channel time, saturating
    assign add_slots = is_idle ? cbcs_pkg::TX_W'(1) : (ctl.success ? tx_reg : '0);
    assign time_sum  = {1'b0, time_reg} + (cbcs_pkg::TIME_W + 1)'(add_slots);

    always_comb
    begin
        if (is_start)
            time_next = '0;
        else if (time_sum[cbcs_pkg::TIME_W])
            time_next = '1;
        else
            time_next = time_sum[cbcs_pkg::TIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_reg <= '0;
        else if (advance)
            time_reg <= time_next;
    end

    // result fields
    always_comb
    begin
        r_winner = '0;
        r_mask   = '0;
        r_slots  = '0;
        r_att    = '0;
        r_suc    = '0;
        r_time   = time_next;
        if (is_start)
        begin
            r_outcome = cbcs_pkg::OUT_INIT;
        end
        else
        begin
            r_mask = mask;
            if (is_idle)
            begin
                r_outcome = cbcs_pkg::OUT_IDLE;
                r_slots   = cbcs_pkg::TX_W'(1);
            end
            else if (is_coll)
            begin
                r_outcome = cbcs_pkg::OUT_COLLISION;
            end
            else
            begin
                r_outcome = ctl.defer ? cbcs_pkg::OUT_DEFERRED : cbcs_pkg::OUT_SUCCESS;
                r_slots   = ctl.defer ? '0 : tx_reg;
                r_winner  = win_idx;
                r_att     = win_att;
                r_suc     = win_suc;
            end
        end
        res_next = {r_time, r_suc, r_att, r_slots, r_mask, r_winner, r_outcome};
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // checks
    a_hold_time: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(time_reg))
        else $error("channel time moved without a round");

    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_idle |=> res_reg[cbcs_pkg::OUTCOME_W-1:0] == cbcs_pkg::OUT_IDLE
            && res_reg[16:9] == cbcs_pkg::TX_W'(1))
        else $error("idle round must report one slot");

    a_coll_nowin: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_coll |=> res_reg[4:3] == '0 && res_reg[16:9] == '0)
        else $error("collision reported a winner or channel time");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_start |=> time_reg == '0)
        else $error("start did not clear channel time");

endmodule
